// ----- src/record_key_sorter_assert.svh -----
// Assertion macros for the record key sorter
`ifndef RECORD_KEY_SORTER_ASSERT_SVH
`define RECORD_KEY_SORTER_ASSERT_SVH

// Check outside reset only
`define RKS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check at every edge, reset included
`define RKS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rks_pkg.sv -----
`default_nettype none

package rks_pkg;

	localparam int unsigned SORT_KEY_W = 64;
	localparam int unsigned REC_IDX_W  = 16;
	localparam int unsigned TDATA_W    = 80;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;
		logic shift;
	} rks_cmd_t;

	// What a cell tells its right-hand neighbor about itself
	typedef struct packed {
		logic occ;
		logic gt;
	} rks_link_t;

endpackage

`default_nettype wire

// ----- src/rks_cell.sv -----
`default_nettype none

module rks_cell
	import rks_pkg::*;
#(
	parameter int unsigned IDX   = 0,
	parameter int unsigned KEY_W = 64,
	parameter int unsigned CNT_W = 7
) (
	input  wire logic                 clk,
	input  wire rks_cmd_t             cmd,
	input  wire logic [KEY_W-1:0]     new_key,
	input  wire logic [REC_IDX_W-1:0] new_idx,
	input  wire logic [CNT_W-1:0]     cnt,
	input  wire rks_link_t            left_link,
	input  wire logic [KEY_W-1:0]     left_key,
	input  wire logic [REC_IDX_W-1:0] left_idx,
	input  wire logic [KEY_W-1:0]     right_key,
	input  wire logic [REC_IDX_W-1:0] right_idx,
	output rks_link_t                 link,
	output logic [KEY_W-1:0]          key,
	output logic [REC_IDX_W-1:0]      idx
);

	logic [KEY_W-1:0]     key_q;
	logic [REC_IDX_W-1:0] idx_q;
	logic                 occ;
	logic                 gt;
	logic                 take_left;
	logic                 take_new;

	assign occ = (CNT_W'(IDX) < cnt);
	assign gt  = occ && (key_q > new_key);

	// Left neighbor pushes its record in when it holds a greater key;
	// the first cell not holding a smaller-or-equal key takes the new one.
	assign take_left = left_link.gt;
	assign take_new  = !left_link.gt && left_link.occ && (gt || !occ);

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			key_q <= right_key;
			idx_q <= right_idx;
		end else if (cmd.insert && take_left) begin
			key_q <= left_key;
			idx_q <= left_idx;
		end else if (cmd.insert && take_new) begin
			key_q <= new_key;
			idx_q <= new_idx;
		end
	end

	assign link = '{occ: occ, gt: gt};
	assign key  = key_q;
	assign idx  = idx_q;

endmodule

`default_nettype wire

// ----- src/record_key_sorter.sv -----
// Insertion: one item per cycle, all cells compare against the new key in parallel.
// Output: after the item with tlast, the stored items leave one per cycle from
// cell 0 whenever the output register is empty or m_tready is high.
// No input is taken while the chain drains. Overflowing items are dropped.
// Reset clears the fill count, drop flag, drain state and output valid.
`default_nettype none

`include "record_key_sorter_assert.svh"

module record_key_sorter
	import rks_pkg::*;
#(
	parameter int unsigned CAPACITY  = 64,
	parameter int unsigned KEY_BYTES = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // sort_key[63:0], record_index[79:64]
	input  wire logic               s_tlast,  // final_item
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,  // sorted_key[63:0], sorted_index[79:64]
	output logic                    m_tlast,  // run_end
	output logic                    m_tuser   // overflowed
);

	localparam int unsigned KEY_W = 8 * KEY_BYTES;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic                 drop_q;
	logic                 drain_q;
	logic                 m_valid_q;
	logic [KEY_W-1:0]     m_key_q;
	logic [REC_IDX_W-1:0] m_idx_q;
	logic                 m_last_q;
	logic                 m_ovf_q;

	logic                 acc;
	logic                 full;
	logic                 pop;
	logic                 pop_last;
	rks_cmd_t             cmd;
	logic [KEY_W-1:0]     in_key;
	logic [REC_IDX_W-1:0] in_idx;

	rks_link_t            lnk      [0:CAPACITY];
	logic [KEY_W-1:0]     cell_key [0:CAPACITY];
	logic [REC_IDX_W-1:0] cell_idx [0:CAPACITY];

	assign s_tready = !drain_q;
	assign acc      = s_tvalid && s_tready;
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign pop      = drain_q && (!m_valid_q || m_tready);
	assign pop_last = pop && (cnt_q == CNT_W'(1));
	assign in_key   = s_tdata[KEY_W-1:0];
	assign in_idx   = s_tdata[SORT_KEY_W +: REC_IDX_W];
	assign cmd      = '{insert: acc && !full, shift: pop};

	// Cell 0 sees an occupied, never-greater neighbor on its left
	assign lnk[0]             = '{occ: 1'b1, gt: 1'b0};
	assign cell_key[CAPACITY] = '0;
	assign cell_idx[CAPACITY] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_W-1:0]     lk;
		logic [REC_IDX_W-1:0] li;

		if (i == 0) begin : g_first
			assign lk = in_key;
			assign li = in_idx;
		end else begin : g_rest
			assign lk = cell_key[i-1];
			assign li = cell_idx[i-1];
		end

		rks_cell #(
			.IDX   (i),
			.KEY_W (KEY_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.new_key   (in_key),
			.new_idx   (in_idx),
			.cnt       (cnt_q),
			.left_link (lnk[i]),
			.left_key  (lk),
			.left_idx  (li),
			.right_key (cell_key[i+1]),
			.right_idx (cell_idx[i+1]),
			.link      (lnk[i+1]),
			.key       (cell_key[i]),
			.idx       (cell_idx[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			drain_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (s_tlast) begin
					drain_q <= 1'b1;
				end
			end
			if (pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (pop_last) begin
					drain_q <= 1'b0;
					drop_q  <= 1'b0;
				end
			end
			if (pop) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_key_q  <= cell_key[0];
			m_idx_q  <= cell_idx[0];
			m_last_q <= pop_last;
			m_ovf_q  <= pop_last && drop_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_idx_q, SORT_KEY_W'(m_key_q)};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_ovf_q;

	`RKS_ASSERT_ALWAYS(a_cnt_bound, !arst_n || cnt_q <= CNT_W'(CAPACITY), "fill count above capacity")
	`RKS_ASSERT(a_drain_nonempty, !(drain_q && cnt_q == '0), "draining an empty chain")
	`RKS_ASSERT(a_run_close, pop_last |=> (!drain_q && cnt_q == '0 && !drop_q), "run not closed")
	`RKS_ASSERT(a_ovf_on_last, (m_tvalid && m_tuser) |-> m_tlast, "overflow flag off the last item")

endmodule

`default_nettype wire
